@@ hdl/deadline_timer_queue_unit_assert.svh @@
// Assertion macros for the deadline timer queue.
`ifndef DEADLINE_TIMER_QUEUE_UNIT_ASSERT_SVH
`define DEADLINE_TIMER_QUEUE_UNIT_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define DTQ_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define DTQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define DTQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/dtq_pkg.sv @@
// Codes and fixed field widths of the deadline timer queue.
package dtq_pkg;

    localparam int TIME_W    = 32;
    localparam int KIND_W    = 3;
    localparam int EID_W     = 16;
    localparam int RES_ID_W  = 16;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 56;

    // Command kinds
    localparam logic [KIND_W-1:0] KIND_SCHEDULE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CANCEL   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TICK     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_QUERY    = 3'd4;

    // Result kinds
    localparam logic [KIND_W-1:0] RES_SCHEDULED   = 3'd0;
    localparam logic [KIND_W-1:0] RES_FIRED       = 3'd1;
    localparam logic [KIND_W-1:0] RES_QUERY       = 3'd2;
    localparam logic [KIND_W-1:0] RES_FULL        = 3'd3;
    localparam logic [KIND_W-1:0] RES_CANCEL_DONE = 3'd4;
    localparam logic [KIND_W-1:0] RES_TICK_DONE   = 3'd5;

endpackage

@@ hdl/deadline_timer_queue_unit.sv @@
// Deadline timer queue: timer table in one memory, scanned by a small sequencer.
//
// Holds up to SLOTS timers (identifier and deadline) in insertion order in a
// single memory with a registered read. Schedule and clear stay in the idle
// state: the result is valid the cycle after the beat is accepted and the next
// beat can be taken then. Query and cancel make one pass over the table,
// reading one entry per cycle through the single read port. A tick that fires
// F timers makes F+1 search passes, emits each fired timer from the emit state
// and ends with one compaction pass. Holding tready low on the result side
// stalls the emit and done states. One command is worked at a time; the next
// is taken once the block is idle and its output register is free or being
// drained.
`include "deadline_timer_queue_unit_assert.svh"

module deadline_timer_queue_unit
    import dtq_pkg::*;
#(
    parameter int SLOTS   = 16,
    parameter int ID_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // time_value[31:0], entry_id[47:32]
    input  logic [KIND_W-1:0]    s_tuser,   // kind[2:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // result_id[15:0], fired_time[47:16],
                                            // pending[48], zero[55:49]
    output logic [KIND_W-1:0]    m_tuser,   // result_kind[2:0]
    output logic                 m_tlast
);

    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int ENT_W = ID_BITS + TIME_W;
    localparam int CMP_W = (ID_BITS > EID_W) ? ID_BITS : EID_W;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SCAN    = 3'd1;
    localparam logic [2:0] ST_EMIT    = 3'd2;
    localparam logic [2:0] ST_COMPACT = 3'd3;
    localparam logic [2:0] ST_DONE    = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [KIND_W-1:0]   op_reg, op_next;
    logic [TIME_W-1:0]   tv_reg, tv_next;
    logic [EID_W-1:0]    eid_reg, eid_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [ID_BITS-1:0]  next_id_reg, next_id_next;
    logic [CW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [AW-1:0]       rd_idx_reg, rd_idx_next;
    logic [CW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [SLOTS-1:0]    drop_reg, drop_next;
    logic                found_reg, found_next;
    logic [AW-1:0]       best_idx_reg, best_idx_next;
    logic [TIME_W-1:0]   best_dl_reg, best_dl_next;
    logic [ID_BITS-1:0]  best_id_reg, best_id_next;

    logic                out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]   out_kind_reg, out_kind_next;
    logic [RES_ID_W-1:0] out_id_reg, out_id_next;
    logic [TIME_W-1:0]   out_time_reg, out_time_next;
    logic                out_pend_reg, out_pend_next;
    logic                out_last_reg, out_last_next;

    logic [ENT_W-1:0]    mem [SLOTS];
    logic [ENT_W-1:0]    rd_data_reg;

    logic                out_free;
    logic                scanning;
    logic                rd_en;
    logic                pass_end;
    logic [ID_BITS-1:0]  rd_id;
    logic [TIME_W-1:0]   rd_dl;
    logic                id_hit;
    logic                due;
    logic                better;
    logic                keep;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [ENT_W-1:0]    wr_data;
    logic                accept;

    assign out_free = !out_valid_reg || m_tready;
    assign scanning = (state_reg == ST_SCAN) || (state_reg == ST_COMPACT);
    assign rd_en    = scanning && (rd_ptr_reg < count_reg);
    assign pass_end = scanning && (rd_ptr_reg == count_reg) && !rd_vld_reg;

    assign rd_id  = rd_data_reg[ID_BITS-1:0];
    assign rd_dl  = rd_data_reg[ENT_W-1:ID_BITS];
    // ids compare at the wider of the two widths, so extra high bits never match
    assign id_hit = rd_vld_reg && (CMP_W'(rd_id) == CMP_W'(eid_reg));
    assign due    = rd_vld_reg && !drop_reg[rd_idx_reg] && (rd_dl <= tv_reg);
    assign better = due && (!found_reg || (rd_dl < best_dl_reg));
    assign keep   = (op_reg == KIND_TICK) ? !drop_reg[rd_idx_reg] : !id_hit;

    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        tv_next       = tv_reg;
        eid_next      = eid_reg;
        count_next    = count_reg;
        next_id_next  = next_id_reg;
        rd_ptr_next   = rd_ptr_reg;
        rd_vld_next   = rd_en;
        rd_idx_next   = rd_ptr_reg[AW-1:0];
        wr_ptr_next   = wr_ptr_reg;
        drop_next     = drop_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_dl_next  = best_dl_reg;
        best_id_next  = best_id_reg;
        out_valid_next = m_tready ? 1'b0 : out_valid_reg;
        out_kind_next = out_kind_reg;
        out_id_next   = out_id_reg;
        out_time_next = out_time_reg;
        out_pend_next = out_pend_reg;
        out_last_next = out_last_reg;
        wr_en         = 1'b0;
        wr_addr       = wr_ptr_reg[AW-1:0];
        wr_data       = rd_data_reg;

        if (rd_en)
        begin
            rd_ptr_next = rd_ptr_reg + CW'(1);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next     = s_tuser;
                    tv_next     = s_tdata[TIME_W-1:0];
                    eid_next    = s_tdata[TIME_W+EID_W-1:TIME_W];
                    rd_ptr_next = '0;
                    wr_ptr_next = '0;
                    found_next  = 1'b0;
                    drop_next   = '0;
                    unique case (s_tuser) inside
                        KIND_SCHEDULE:
                        begin
                            out_valid_next = 1'b1;
                            out_time_next  = '0;
                            out_pend_next  = 1'b0;
                            out_last_next  = 1'b1;
                            if (count_reg == CW'(SLOTS))
                            begin
                                out_kind_next = RES_FULL;
                                out_id_next   = '0;
                            end
                            else
                            begin
                                wr_en         = 1'b1;
                                wr_addr       = count_reg[AW-1:0];
                                wr_data       = {s_tdata[TIME_W-1:0], next_id_reg};
                                count_next    = count_reg + CW'(1);
                                next_id_next  = next_id_reg + ID_BITS'(1);
                                out_kind_next = RES_SCHEDULED;
                                out_id_next   = RES_ID_W'(next_id_reg);
                            end
                        end
                        KIND_CANCEL:
                        begin
                            state_next = ST_COMPACT;
                        end
                        KIND_CLEAR:
                        begin
                            count_next     = '0;
                            out_valid_next = 1'b1;
                            out_kind_next  = RES_CANCEL_DONE;
                            out_id_next    = '0;
                            out_time_next  = '0;
                            out_pend_next  = 1'b0;
                            out_last_next  = 1'b1;
                        end
                        KIND_TICK, KIND_QUERY:
                        begin
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (op_reg == KIND_QUERY)
                begin
                    if (id_hit)
                    begin
                        found_next = 1'b1;
                    end
                end
                else if (better)
                begin
                    found_next    = 1'b1;
                    best_idx_next = rd_idx_reg;
                    best_dl_next  = rd_dl;
                    best_id_next  = rd_id;
                end
                if (pass_end)
                begin
                    rd_ptr_next = '0;
                    wr_ptr_next = '0;
                    if (op_reg == KIND_QUERY)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (found_reg)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_COMPACT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_kind_next           = RES_FIRED;
                    out_id_next             = RES_ID_W'(best_id_reg);
                    out_time_next           = best_dl_reg;
                    out_pend_next           = 1'b0;
                    out_last_next           = 1'b0;
                    drop_next[best_idx_reg] = 1'b1;
                    found_next              = 1'b0;
                    rd_ptr_next             = '0;
                    state_next              = ST_SCAN;
                end
            end
            ST_COMPACT:
            begin
                // write side trails the read side, so survivors slide down in order
                if (rd_vld_reg && keep)
                begin
                    wr_en       = 1'b1;
                    wr_addr     = wr_ptr_reg[AW-1:0];
                    wr_data     = rd_data_reg;
                    wr_ptr_next = wr_ptr_reg + CW'(1);
                end
                if (pass_end)
                begin
                    count_next = wr_ptr_reg;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_time_next  = '0;
                    out_last_next  = 1'b1;
                    out_pend_next  = 1'b0;
                    out_id_next    = eid_reg;
                    case (op_reg)
                        KIND_TICK:
                        begin
                            out_kind_next = RES_TICK_DONE;
                            out_id_next   = '0;
                        end
                        KIND_QUERY:
                        begin
                            out_kind_next = RES_QUERY;
                            out_pend_next = found_reg;
                        end
                        default:
                        begin
                            out_kind_next = RES_CANCEL_DONE;
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            next_id_reg   <= ID_BITS'(1);
            rd_ptr_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            wr_ptr_reg    <= '0;
            drop_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            next_id_reg   <= next_id_next;
            rd_ptr_reg    <= rd_ptr_next;
            rd_vld_reg    <= rd_vld_next;
            wr_ptr_reg    <= wr_ptr_next;
            drop_reg      <= drop_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        tv_reg       <= tv_next;
        eid_reg      <= eid_next;
        rd_idx_reg   <= rd_idx_next;
        best_idx_reg <= best_idx_next;
        best_dl_reg  <= best_dl_next;
        best_id_reg  <= best_id_next;
        out_kind_reg <= out_kind_next;
        out_id_reg   <= out_id_next;
        out_time_reg <= out_time_next;
        out_pend_reg <= out_pend_next;
        out_last_reg <= out_last_next;
    end

    // timer table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_ptr_reg[AW-1:0]];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {(M_TDATA_W - RES_ID_W - TIME_W - 1)'(0), out_pend_reg, out_time_reg,
                       out_id_reg};

    `DTQ_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(SLOTS), "slot count exceeds table size")
    `DTQ_ASSERT_IMPL(a_compact_order, (state_reg == ST_COMPACT) && rd_vld_reg,
        wr_ptr_reg <= CW'(rd_idx_reg), "compaction write overtook read")
    `DTQ_ASSERT_NEXT(a_sched_grow,
        accept && (s_tuser == KIND_SCHEDULE) && (count_reg < CW'(SLOTS)),
        count_reg == $past(count_reg) + CW'(1), "schedule did not store a timer")
    `DTQ_ASSERT_IMPL(a_fired_due, m_tvalid && (m_tuser == RES_FIRED),
        (out_time_reg <= tv_reg) && !m_tlast, "fired timer not due or marked last")
    `DTQ_ASSERT_IMPL(a_emit_found, state_reg == ST_EMIT, found_reg,
        "emit state without a selected timer")

endmodule
